FILE: design/pulse_width_ook_frame_encoder_macros.svh
// Assertion macros shared by the pulse-width OOK frame encoder modules.
// Expects signals named clock and reset in the module that uses them.
`ifndef PULSE_WIDTH_OOK_FRAME_ENCODER_MACROS_SVH
`define PULSE_WIDTH_OOK_FRAME_ENCODER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PWOOK_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define PWOOK_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/pwook_pkg.sv
// Package for the pulse-width OOK frame encoder: constants, codes and types.
// No dependencies.
package pwook_pkg;

   localparam int MESSAGE_BYTES  = 6;
   localparam int POS_W          = $clog2(MESSAGE_BYTES + 1);
   localparam int PREAMBLE_BYTES = 4;
   localparam int SYNC_ZEROS     = 12;
   localparam int STEP_W         = 4;

   localparam logic [7:0] PREAMBLE_BYTE  = 8'hAA;
   localparam logic [5:0] SYM_ZERO_CHIPS = 6'h0C;
   localparam logic [5:0] SYM_ONE_CHIPS  = 6'h38;
   localparam logic [3:0] SYM_ZERO_LEN   = 4'd4;
   localparam logic [3:0] SYM_ONE_LEN    = 4'd6;

   // Configuration register indexes
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_PREAMBLE_EN = 2'd0;
   localparam logic [1:0] REG_APPEND_CHK  = 2'd1;
   localparam logic [1:0] REG_CHK_SEED    = 2'd2;

   // Queue sizes
   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
   localparam int OUTQ_DEPTH = 4;
   localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

   typedef struct packed {
      logic       preamble_en;
      logic       append_chk;
      logic [7:0] seed;
   } cfg_type;

   // One classified message byte, handed from front to back
   typedef struct packed {
      logic [7:0] data;
      logic       first;
      logic       preamble;
      logic       last;
      logic       chk_on;
      logic [7:0] chk;
   } cmd_type;

   typedef struct packed {
      logic [7:0] line;
      logic       frame_end;
   } line_word_type;

endpackage

FILE: design/pwook_front.sv
// Front end: accepts message bytes, tracks frame position and checksum,
// and queues one classified command per byte. Depends on pwook_pkg.
`include "pulse_width_ook_frame_encoder_macros.svh"

module pwook_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [7:0]        data_byte,
   input  pwook_pkg::cfg_type cfg,
   output logic              cmd_valid,
   output pwook_pkg::cmd_type cmd,
   input  logic              cmd_take
);
   import pwook_pkg::*;

   logic [POS_W-1:0]      pos_ff, pos_in, pos_next, end_at;
   logic [7:0]            sum_ff, sum_in, sum_new;
   logic [CMDQ_PTR_W-1:0] wr_ff, rd_ff;
   logic [CMDQ_CNT_W-1:0] cnt_ff, cnt_in;
   cmd_type               mem_ff [CMDQ_DEPTH];
   cmd_type               new_cmd;
   logic                  accept, first;

   assign full      = (cnt_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = mem_ff[rd_ff];
   assign accept    = push & ~full;

   // Classify the incoming byte
   always_comb begin
      first    = (pos_ff == '0);
      sum_new  = 8'((first ? 8'd0 : sum_ff) + data_byte);
      pos_next = POS_W'(pos_ff + 1'b1);
      end_at   = cfg.append_chk ? POS_W'(MESSAGE_BYTES - 1) : POS_W'(MESSAGE_BYTES);
      new_cmd.data     = data_byte;
      new_cmd.first    = first;
      new_cmd.preamble = first & cfg.preamble_en;
      new_cmd.last     = (pos_next >= end_at);
      new_cmd.chk_on   = cfg.append_chk;
      new_cmd.chk      = 8'(cfg.seed + sum_new);
   end

   // Advance frame position; restart after the last byte
   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      if (accept) begin
         pos_in = new_cmd.last ? '0 : pos_next;
         sum_in = new_cmd.last ? 8'd0 : sum_new;
      end
      cnt_in = CMDQ_CNT_W'(cnt_ff + (accept ? 1'b1 : 1'b0) - (cmd_take ? 1'b1 : 1'b0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         sum_ff <= '0;
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
         if (accept) wr_ff <= CMDQ_PTR_W'(wr_ff + 1'b1);
         if (cmd_take) rd_ff <= CMDQ_PTR_W'(rd_ff + 1'b1);
      end
   end

   // Command storage
   always_ff @(posedge clock) begin
      if (accept) mem_ff[wr_ff] <= new_cmd;
   end

   `PWOOK_ASSERT_IMP(a_take_needs_cmd, cmd_take, cnt_ff != '0, "command taken from empty queue")

endmodule

FILE: design/pwook_back.sv
// Back end: runs one command as a sequence of pulse symbols and packs the
// chips into line words, one symbol per cycle while the output queue is not full. Depends on pwook_pkg.
`include "pulse_width_ook_frame_encoder_macros.svh"

module pwook_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_valid,
   input  pwook_pkg::cmd_type       cmd,
   output logic                     cmd_take,
   input  logic                     out_full,
   output logic                     out_push,
   output pwook_pkg::line_word_type out_word
);
   import pwook_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PRE   = 3'd1;
   localparam logic [2:0] ST_SYNC  = 3'd2;
   localparam logic [2:0] ST_DATA  = 3'd3;
   localparam logic [2:0] ST_CHK   = 3'd4;
   localparam logic [2:0] ST_TAIL  = 3'd5;
   localparam logic [2:0] ST_FLUSH = 3'd6;

   logic [2:0]        state_ff, state_in, start_state;
   logic [STEP_W-1:0] step_ff, step_in;
   cmd_type           cur_ff, cur_in;
   logic [7:0]        acc_ff, acc_in, sym_byte, emitted, keep, flush_line;
   logic [2:0]        nchip_ff, nchip_in, rem;
   logic              go, sym_bit, spill, finish;
   logic [5:0]        sym_chips;
   logic [3:0]        sym_len, total;
   logic [13:0]       wide;

   assign go = ~out_full;

   // Pick the symbol of this step
   always_comb begin
      sym_byte = (state_ff == ST_CHK) ? cur_ff.chk : cur_ff.data;
      case (state_ff)
         ST_SYNC: sym_bit = (step_ff == STEP_W'(SYNC_ZEROS));
         ST_DATA, ST_CHK: sym_bit = (step_ff < STEP_W'(8)) ? sym_byte[~step_ff[2:0]] : ^sym_byte;
         default: sym_bit = 1'b0;
      endcase
      sym_chips = sym_bit ? SYM_ONE_CHIPS : SYM_ZERO_CHIPS;
      sym_len   = sym_bit ? SYM_ONE_LEN : SYM_ZERO_LEN;
   end

   // Pack chips: emit the top eight once eight or more are held
   always_comb begin
      total      = 4'({1'b0, nchip_ff} + sym_len);
      spill      = total[3];
      rem        = total[2:0];
      wide       = (14'(acc_ff) << sym_len) | 14'(sym_chips);
      emitted    = 8'(wide >> rem);
      keep       = 8'(wide & ((14'd1 << rem) - 14'd1));
      flush_line = acc_ff << 3'(4'd8 - {1'b0, nchip_ff});
      if (cmd.preamble) start_state = ST_PRE;
      else if (cmd.first) start_state = ST_SYNC;
      else start_state = ST_DATA;
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cur_in   = cur_ff;
      acc_in   = acc_ff;
      nchip_in = nchip_ff;
      out_push = 1'b0;
      out_word = '{line: emitted, frame_end: 1'b0};
      finish   = 1'b0;
      cmd_take = 1'b0;

      if (state_ff != ST_IDLE && go) begin
         // Symbol states share the packer
         if (state_ff inside {ST_SYNC, ST_DATA, ST_CHK, ST_TAIL}) begin
            if (spill) begin
               out_push = 1'b1;
               acc_in   = keep;
               nchip_in = rem;
            end else begin
               acc_in   = wide[7:0];
               nchip_in = total[2:0];
            end
         end
         step_in = STEP_W'(step_ff + 1'b1);
         case (state_ff)
            ST_PRE: begin
               out_push = 1'b1;
               out_word = '{line: PREAMBLE_BYTE, frame_end: 1'b0};
               if (step_ff == STEP_W'(PREAMBLE_BYTES - 1)) begin
                  state_in = ST_SYNC;
                  step_in  = '0;
               end
            end
            ST_SYNC: begin
               if (step_ff == STEP_W'(SYNC_ZEROS)) begin
                  state_in = ST_DATA;
                  step_in  = '0;
               end
            end
            ST_DATA: begin
               if (step_ff == STEP_W'(8)) begin
                  step_in = '0;
                  if (!cur_ff.last) finish = 1'b1;
                  else if (cur_ff.chk_on) state_in = ST_CHK;
                  else state_in = ST_TAIL;
               end
            end
            ST_CHK: begin
               if (step_ff == STEP_W'(8)) begin
                  state_in = ST_TAIL;
                  step_in  = '0;
               end
            end
            ST_TAIL: begin
               if (step_ff == STEP_W'(1)) begin
                  step_in = '0;
                  // Frame ends on this word when nothing is left over
                  if (spill && rem == '0) begin
                     out_word.frame_end = 1'b1;
                     finish = 1'b1;
                  end else begin
                     state_in = ST_FLUSH;
                  end
               end
            end
            ST_FLUSH: begin
               out_push = 1'b1;
               out_word = '{line: flush_line, frame_end: 1'b1};
               acc_in   = '0;
               nchip_in = '0;
               step_in  = '0;
               finish   = 1'b1;
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end

      // Load the next command, or drop to idle
      if (state_ff == ST_IDLE || finish) begin
         if (cmd_valid) begin
            cmd_take = 1'b1;
            cur_in   = cmd;
            state_in = start_state;
            step_in  = '0;
         end else begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         acc_ff   <= '0;
         nchip_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         acc_ff   <= acc_in;
         nchip_ff <= nchip_in;
      end
   end

   // Command payload
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   `PWOOK_ASSERT_IMP(a_pre_step, state_ff == ST_PRE, step_ff < STEP_W'(PREAMBLE_BYTES), "preamble step out of range")
   `PWOOK_ASSERT_IMP(a_end_place, out_push && out_word.frame_end, state_ff == ST_TAIL || state_ff == ST_FLUSH, "frame end outside tail")
   `PWOOK_ASSERT_NEXT(a_take_starts, cmd_take, state_ff != ST_IDLE, "command taken but sequencer idle")

endmodule

FILE: design/pwook_outq.sv
// Output queue: holds finished line words until the consumer pops them.
// Depends on pwook_pkg.
`include "pulse_width_ook_frame_encoder_macros.svh"

module pwook_outq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  pwook_pkg::line_word_type word,
   output logic                     full,
   output logic                     empty,
   input  logic                     pop,
   output pwook_pkg::line_word_type head
);
   import pwook_pkg::*;

   line_word_type         mem_ff [OUTQ_DEPTH];
   logic [OUTQ_PTR_W-1:0] wr_ff, rd_ff;
   logic [OUTQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  do_pop;

   assign full   = (cnt_ff == OUTQ_CNT_W'(OUTQ_DEPTH));
   assign empty  = (cnt_ff == '0);
   assign head   = mem_ff[rd_ff];
   assign do_pop = pop & ~empty;
   assign cnt_in = OUTQ_CNT_W'(cnt_ff + (push ? 1'b1 : 1'b0) - (do_pop ? 1'b1 : 1'b0));

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ff <= OUTQ_PTR_W'(wr_ff + 1'b1);
         if (do_pop) rd_ff <= OUTQ_PTR_W'(rd_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= word;
   end

   `PWOOK_ASSERT_IMP(a_no_overflow, push, !full, "word pushed into full output queue")

endmodule

FILE: design/pulse_width_ook_frame_encoder.sv
// Top level of the pulse-width OOK frame encoder: configuration registers,
// front end, back end and output queue. Depends on pwook_pkg and submodules.
//
//   channel  ports                            handshake
//   -------  -------------------------------  ---------------------------
//   request  req_data_byte                    push / full
//   response rsp_line_byte, rsp_frame_end     pop / empty
//   config   psel penable pwrite paddr ...    APB write, pready tied high
//
// The back end runs one pulse symbol per cycle unless the output queue is
// full. A middle byte is eight data symbols plus parity; a frame's first
// byte adds optional preamble words and sync symbols, the last adds optional
// checksum symbols, two tail zeros and up to one flush word. Bytes and line
// words queue in four-entry command and output queues, so either side may
// stall. Synchronous active-high reset restores the register defaults.
module pulse_width_ook_frame_encoder (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             full,
   input  logic [7:0]                       req_data_byte,
   output logic                             empty,
   input  logic                             pop,
   output logic [7:0]                       rsp_line_byte,
   output logic                             rsp_frame_end,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [pwook_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import pwook_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   cmd_type       cmd;
   line_word_type back_word, head;
   logic          cmd_valid, cmd_take, out_full, out_push, csr_write;
   logic [1:0]    csr_index;

   assign pready    = 1'b1;
   assign csr_index = paddr[3:2];
   assign csr_write = psel & penable & pwrite & pready;

   // Write configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_PREAMBLE_EN: cfg_in.preamble_en = pwdata[0];
            REG_APPEND_CHK:  cfg_in.append_chk  = pwdata[0];
            REG_CHK_SEED:    cfg_in.seed        = pwdata[7:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{preamble_en: 1'b1, append_chk: 1'b1, seed: 8'd12};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back configuration
   always_comb begin
      case (csr_index)
         REG_PREAMBLE_EN: prdata = {31'd0, cfg_ff.preamble_en};
         REG_APPEND_CHK:  prdata = {31'd0, cfg_ff.append_chk};
         REG_CHK_SEED:    prdata = {24'd0, cfg_ff.seed};
         default:         prdata = '0;
      endcase
   end

   pwook_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .data_byte (req_data_byte),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take)
   );

   pwook_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_word  (back_word)
   );

   pwook_outq u_outq (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .word  (back_word),
      .full  (out_full),
      .empty (empty),
      .pop   (pop),
      .head  (head)
   );

   assign rsp_line_byte = head.line;
   assign rsp_frame_end = head.frame_end;

endmodule

FILE: bench/pulse_width_ook_frame_encoder_tb.sv
// Self-checking bench for pulse_width_ook_frame_encoder: drives message bytes,
// rewrites the APB registers between phases and scores every popped line word.
// Depends on pwook_pkg and the encoder RTL only.
`timescale 1ns / 1ps

module pulse_width_ook_frame_encoder_tb;
   import pwook_pkg::*;

   localparam int WORD_LIMIT     = 20;
   localparam int STALL_LIMIT    = 3000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int TAIL_CYCLES    = 60;
   localparam int TOTAL_BYTES    = 260;
   localparam int QUIET_FROM     = 210;
   localparam int REPORT_LIMIT   = 10;

   // Line-coding predictor and store of expected line words
   class frame_scoreboard;
      bit         preamble_on;
      bit         checksum_on;
      bit [7:0]   seed;
      bit [7:0]   chip_acc;
      int         chip_cnt;
      int         byte_pos;
      bit [7:0]   byte_sum;
      int         words_now;
      int         errors;
      line_word_type expected_words[$];

      function new();
         preamble_on = 1'b1;
         checksum_on = 1'b1;
         seed        = 8'd12;
         chip_acc    = '0;
         chip_cnt    = 0;
         byte_pos    = 0;
         byte_sum    = '0;
         errors      = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] data);
         case (idx)
            REG_PREAMBLE_EN: preamble_on = data[0];
            REG_APPEND_CHK:  checksum_on = data[0];
            REG_CHK_SEED:    seed        = data[7:0];
            default: ;
         endcase
      endfunction

      function void emit_word(bit [7:0] v);
         line_word_type w;
         if (words_now < WORD_LIMIT) begin
            w.line      = v;
            w.frame_end = 1'b0;
            expected_words.push_back(w);
            words_now++;
         end
      endfunction

      function void add_chip(bit c);
         chip_acc = {chip_acc[6:0], c};
         chip_cnt++;
         if (chip_cnt >= 8) begin
            emit_word(chip_acc);
            chip_acc = '0;
            chip_cnt = 0;
         end
      endfunction

      function void add_symbol(bit one);
         logic [5:0] chips;
         int len;
         chips = one ? SYM_ONE_CHIPS : SYM_ZERO_CHIPS;
         len   = one ? int'(SYM_ONE_LEN) : int'(SYM_ZERO_LEN);
         for (int i = len - 1; i >= 0; i--)
            add_chip(chips[i]);
      endfunction

      // Eight data symbols MSB first, then the even-parity symbol
      function void add_byte(bit [7:0] b);
         for (int i = 7; i >= 0; i--)
            add_symbol(b[i]);
         add_symbol(^b);
      endfunction

      function void note_byte(bit [7:0] b);
         line_word_type w;
         int end_at;
         words_now = 0;
         if (byte_pos == 0) begin
            chip_acc = '0;
            chip_cnt = 0;
            byte_sum = '0;
            if (preamble_on)
               for (int i = 0; i < PREAMBLE_BYTES; i++)
                  emit_word(PREAMBLE_BYTE);
            for (int i = 0; i < SYNC_ZEROS; i++)
               add_symbol(1'b0);
            add_symbol(1'b1);
         end
         add_byte(b);
         byte_sum = byte_sum + b;
         byte_pos++;
         end_at = checksum_on ? MESSAGE_BYTES - 1 : MESSAGE_BYTES;
         // Close the frame: checksum, two tail zeros, left-aligned flush
         if (byte_pos >= end_at) begin
            if (checksum_on)
               add_byte(seed + byte_sum);
            add_symbol(1'b0);
            add_symbol(1'b0);
            if (chip_cnt > 0)
               emit_word(chip_acc << (8 - chip_cnt));
            if (words_now > 0) begin
               w = expected_words.pop_back();
               w.frame_end = 1'b1;
               expected_words.push_back(w);
            end
            chip_acc = '0;
            chip_cnt = 0;
            byte_pos = 0;
            byte_sum = '0;
         end
      endfunction

      function void check_word(logic [7:0] line, logic frame_end);
         line_word_type w;
         if (expected_words.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("mismatch: unexpected word line=%h frame_end=%b", line, frame_end);
         end else begin
            w = expected_words.pop_front();
            if (line !== w.line || frame_end !== w.frame_end) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("mismatch: expected line=%h frame_end=%b, got line=%h frame_end=%b",
                           w.line, w.frame_end, line, frame_end);
            end
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  push;
   logic                  full;
   logic [7:0]            req_data_byte;
   logic                  empty;
   logic                  pop;
   logic [7:0]            rsp_line_byte;
   logic                  rsp_frame_end;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   frame_scoreboard board = new();
   bit  quiet;
   int  bytes_sent;
   int  idle_cycles;
   int  stall_left;

   pulse_width_ook_frame_encoder uut (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_data_byte (req_data_byte),
      .empty         (empty),
      .pop           (pop),
      .rsp_line_byte (rsp_line_byte),
      .rsp_frame_end (rsp_frame_end),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Consumer: pop with random stall bursts, none in the quiet tail
   initial begin
      pop = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            pop <= 1'b0;
            stall_left--;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            pop <= 1'b0;
            stall_left = $urandom_range(1, 7) - 1;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // Score each popped word against the oldest expectation
   always @(posedge clock) begin
      if (!reset && pop && !empty)
         board.check_word(rsp_line_byte, rsp_frame_end);
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || (psel && penable) || reset)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Push one message byte, with an optional idle burst ahead of it
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         @(negedge clock);
         push <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      push          <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (full);
      board.note_byte(b);
      bytes_sent++;
   endtask

   // Drop push and wait until every expected word has been popped
   task automatic drain();
      @(negedge clock);
      push <= 1'b0;
      while (board.expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle until pready
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'({idx, 2'b00});
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      board.write_reg(idx, data);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Register value in bit 0 or the low byte, noise in the bits above
   task automatic set_config(input bit pre, input bit chk, input logic [7:0] sd);
      logic [31:0] noise;
      noise = $urandom;
      csr_write(REG_PREAMBLE_EN, {noise[31:1], pre});
      noise = $urandom;
      csr_write(REG_APPEND_CHK, {noise[31:1], chk});
      noise = $urandom;
      csr_write(REG_CHK_SEED, {noise[31:8], sd});
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_seed();
      case ($urandom_range(0, 3))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   initial begin
      logic [7:0] frame_a[5];
      logic [7:0] frame_d[5];
      int count;

      frame_a       = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h55};
      frame_d       = '{8'h7F, 8'hFE, 8'hAA, 8'h33, 8'hCC};
      reset         = 1'b1;
      push          = 1'b0;
      req_data_byte = '0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      quiet         = 1'b0;
      bytes_sent    = 0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Default registers: preamble, checksum with seed 12
      foreach (frame_a[i]) send_byte(frame_a[i]);
      drain();

      // No preamble, six input bytes, no checksum
      set_config(1'b0, 1'b0, 8'h00);
      repeat (6) send_byte(8'hFF);
      drain();

      // Preamble back on, checksum with the largest seed
      set_config(1'b1, 1'b1, 8'hFF);
      repeat (5) send_byte(8'hFF);
      drain();

      // Checksum turned on mid-frame after the fifth byte: frame ends past its point
      set_config(1'b1, 1'b0, 8'h80);
      foreach (frame_d[i]) send_byte(frame_d[i]);
      drain();
      set_config(1'b0, 1'b1, 8'h80);
      send_byte(8'h96);
      drain();

      // Random phases; frames often straddle a register change
      while (bytes_sent < TOTAL_BYTES) begin
         set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_seed());
         count = $urandom_range(1, 24);
         for (int i = 0; i < count && bytes_sent < TOTAL_BYTES; i++) begin
            if (bytes_sent >= QUIET_FROM)
               quiet = 1'b1;
            send_byte(pick_byte());
         end
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.expected_words.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
